// ----- sv/cfd_pkg.sv -----
// shared types and constants of the can signal field decoder
package cfd_pkg;

   localparam int MAX_PAYLOAD_BYTES = 64;
   localparam int MAX_SIGNALS       = 16;
   localparam int RESULT_LIMIT      = 16;
   localparam int PAY_AW            = $clog2(MAX_PAYLOAD_BYTES);
   localparam int SIG_AW            = $clog2(MAX_SIGNALS);
   localparam int VALUE_W           = 64;
   localparam int POS_W             = 10;
   localparam int MOTOROLA_JUMP     = 15;
   localparam int CSR_AW            = 2;
   localparam int CSR_DW            = 7;

   // request modes
   localparam logic [1:0] MODE_BYTE   = 2'd0;
   localparam logic [1:0] MODE_DESC   = 2'd1;
   localparam logic [1:0] MODE_DECODE = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_SIGNAL_COUNT = 2'd1;

   // spare role code behaves as plain
   typedef enum logic [1:0] {
      ROLE_PLAIN = 2'd0,
      ROLE_MUX   = 2'd1,
      ROLE_MUXED = 2'd2,
      ROLE_SPARE = 2'd3
   } role_type;

   typedef struct packed {
      logic [8:0]  start_bit;
      logic [6:0]  length;
      logic        motorola;
      logic        is_signed;
      role_type    role;
      logic [15:0] mux_value;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [PAY_AW-1:0] addr;
      logic [7:0]        data;
   } pay_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EVAL,
      ST_EXTRACT,
      ST_FINISH,
      ST_EMIT,
      ST_FLUSH
   } state_type;

endpackage

// ----- sv/cfd_ifs.sv -----
// channel interfaces of the can signal field decoder
interface cfd_req_if
   import cfd_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [5:0]  byte_index;
   logic [7:0]  byte_value;
   logic [3:0]  sig_index;
   logic [8:0]  sig_start_bit;
   logic [6:0]  sig_length;
   logic        sig_motorola;
   logic        sig_signed;
   logic [1:0]  sig_mux_role;
   logic [15:0] sig_mux_value;

   modport source (
      output valid, mode, byte_index, byte_value, sig_index, sig_start_bit,
             sig_length, sig_motorola, sig_signed, sig_mux_role, sig_mux_value,
      input  ready
   );
   modport sink (
      input  valid, mode, byte_index, byte_value, sig_index, sig_start_bit,
             sig_length, sig_motorola, sig_signed, sig_mux_role, sig_mux_value,
      output ready
   );
endinterface

interface cfd_rsp_if
   import cfd_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [3:0]         signal_index;
   logic [VALUE_W-1:0] value_bits;
   logic               last;

   modport source (output valid, signal_index, value_bits, last, input ready);
   modport sink (input valid, signal_index, value_bits, last, output ready);
endinterface

interface cfd_csr_if
   import cfd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/cfd_payload_store.sv -----
// payload byte memory with per-byte written flags and registered read
module cfd_payload_store
   import cfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pay_wr_type        wr,
   input  logic [PAY_AW-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [MAX_PAYLOAD_BYTES];
   logic [MAX_PAYLOAD_BYTES-1:0] written_ff;
   logic [7:0] rd_byte_ff;
   logic       rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_byte_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            written_ff[wr.addr] <= 1'b1;
         end
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   // a byte never written reads as its reset value of zero
   assign rd_data = rd_written_ff ? rd_byte_ff : 8'd0;

endmodule

// ----- sv/can_signal_field_decoder.sv -----
// top level of the can signal field decoder: descriptor table and decode sequencer
//
//   channel   dir   modport  carries
//   req_ch    in    sink     payload byte write, descriptor write or decode command
//   rsp_ch    out   source   signal_index, value_bits, last per decoded signal
//   csr_ch    in    sink     frame_length (index 0), signal_count (index 1)
//
// req_ch is ready only when idle, for byte writes, descriptor writes and decode commands
// decode: each table entry looked at passes ST_LOAD and ST_EVAL; each extraction
//   issues one payload memory read per bit, and each emitted signal passes ST_EMIT
// the first multiplexor is extracted in a first pass, then the table is walked again
// reset clears the written flags of all payload bytes at once, no clearing sweep
// a stalled rsp_ch holds the sequencer only when a second result is ready to go out
module can_signal_field_decoder
   import cfd_pkg::*;
(
   input logic      clock,
   input logic      reset,
   cfd_req_if.sink  req_ch,
   cfd_rsp_if.source rsp_ch,
   cfd_csr_if.sink  csr_ch
);

   // configuration registers
   logic [6:0] frame_length_ff;
   logic [4:0] signal_count_ff;

   // sequencer state
   state_type  state_ff, state_in;
   logic       pass2_ff, pass2_in;
   logic [4:0] idx_ff, idx_in;
   logic [4:0] count_ff, count_in;
   logic       have_sel_ff, have_sel_in;
   logic [VALUE_W-1:0] sel_ff, sel_in;

   // bit walker
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [6:0]         len_ff, len_in;
   logic [6:0]         iss_cnt_ff, iss_cnt_in;
   logic [6:0]         rcv_cnt_ff, rcv_cnt_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               rd_go_ff, rd_go_in;
   logic [2:0]         rd_off_ff, rd_off_in;
   logic               rd_ok_ff, rd_ok_in;

   // result held back until we know whether it is the last one
   logic               hold_vld_ff, hold_vld_in;
   logic [3:0]         hold_index_ff, hold_index_in;
   logic [VALUE_W-1:0] hold_value_ff, hold_value_in;

   // output register
   logic               rsp_vld_ff, rsp_vld_in;
   logic [3:0]         rsp_index_ff, rsp_index_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   // descriptor memory
   desc_type desc_mem [MAX_SIGNALS];
   desc_type desc_rd_ff;
   desc_type desc_wdata;
   logic     desc_we;

   // payload memory ports
   pay_wr_type        pay_wr;
   logic [PAY_AW-1:0] pay_rd_addr;
   logic [7:0]        pay_rd_data;

   // helpers
   logic [6:0]         frame_eff;
   logic [4:0]         count_eff;
   logic               out_free;
   logic               skip;
   logic               last_entry;
   logic               bit_val;
   logic [VALUE_W-1:0] ext_mask;
   logic [VALUE_W-1:0] value_final;
   logic               sign_bit;
   logic [1:0]         wr_role;

   cfd_payload_store u_payload (
      .clock   (clock),
      .reset   (reset),
      .wr      (pay_wr),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   // configuration port; the user must write it only while idle, the block does not enforce this
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= '0;
         signal_count_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FRAME_LENGTH: frame_length_ff <= csr_ch.data;
            CSR_SIGNAL_COUNT: signal_count_ff <= csr_ch.data[4:0];
            default: ;
         endcase
      end
   end

   // frame length past the store and count past the table saturate
   assign frame_eff = (frame_length_ff > 7'(MAX_PAYLOAD_BYTES)) ?
                      7'(MAX_PAYLOAD_BYTES) : frame_length_ff;
   assign count_eff = (signal_count_ff > 5'(MAX_SIGNALS)) ? 5'(MAX_SIGNALS) :
                      (signal_count_ff > 5'(RESULT_LIMIT)) ? 5'(RESULT_LIMIT) :
                      signal_count_ff;

   // descriptor table: written only while idle, read only during decode,
   // so no access to one entry can overlap
   assign wr_role = (req_ch.sig_mux_role == ROLE_SPARE) ? 2'(ROLE_PLAIN) :
                    req_ch.sig_mux_role;

   always_comb begin
      desc_wdata.start_bit  = req_ch.sig_start_bit;
      desc_wdata.length     = req_ch.sig_length;
      desc_wdata.motorola   = req_ch.sig_motorola;
      desc_wdata.is_signed  = req_ch.sig_signed;
      desc_wdata.role       = role_type'(wr_role);
      desc_wdata.mux_value  = req_ch.sig_mux_value;
   end

   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem[req_ch.sig_index[SIG_AW-1:0]] <= desc_wdata;
      end
      desc_rd_ff <= desc_mem[idx_ff[SIG_AW-1:0]];
   end

   assign out_free   = !rsp_vld_ff || rsp_ch.ready;
   assign last_entry = (idx_ff + 5'd1) == count_ff;
   assign bit_val    = rd_ok_ff & pay_rd_data[rd_off_ff];

   // first pass skips all but multiplexors; second pass skips a multiplexed entry unless its value matches the selector
   assign skip = pass2_ff ?
                 (desc_rd_ff.role == ROLE_MUXED &&
                  (!have_sel_ff || {48'd0, desc_rd_ff.mux_value} != sel_ff)) :
                 (desc_rd_ff.role != ROLE_MUX);

   // sign extension: ones above the signal length
   always_comb begin
      for (int k = 0; k < VALUE_W; k++) begin
         ext_mask[k] = (7'(k) >= len_ff);
      end
   end

   assign sign_bit    = acc_ff[6'(len_ff[5:0] - 6'd1)];
   assign value_final = (desc_rd_ff.is_signed && len_ff != 7'd0 && !len_ff[6] && sign_bit) ?
                        (acc_ff | ext_mask) : acc_ff;

   always_comb begin
      state_in      = state_ff;
      pass2_in      = pass2_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      have_sel_in   = have_sel_ff;
      sel_in        = sel_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      iss_cnt_in    = iss_cnt_ff;
      rcv_cnt_in    = rcv_cnt_ff;
      acc_in        = acc_ff;
      rd_go_in      = 1'b0;
      rd_off_in     = rd_off_ff;
      rd_ok_in      = rd_ok_ff;
      hold_vld_in   = hold_vld_ff;
      hold_index_in = hold_index_ff;
      hold_value_in = hold_value_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      pay_wr.en     = 1'b0;
      pay_wr.addr   = req_ch.byte_index[PAY_AW-1:0];
      pay_wr.data   = req_ch.byte_value;
      pay_rd_addr   = pos_ff[PAY_AW+2:3];
      desc_we       = 1'b0;
      req_ch.ready  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               case (req_ch.mode)
                  MODE_BYTE: begin
                     pay_wr.en = ({1'b0, req_ch.byte_index} < 7'(MAX_PAYLOAD_BYTES));
                  end
                  MODE_DESC: begin
                     desc_we = ({1'b0, req_ch.sig_index} < 5'(MAX_SIGNALS));
                  end
                  MODE_DECODE: begin
                     count_in    = count_eff;
                     idx_in      = 5'd0;
                     pass2_in    = 1'b0;
                     have_sel_in = 1'b0;
                     if (count_eff != 5'd0) begin
                        state_in = ST_LOAD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // descriptor read in flight
         ST_LOAD: begin
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            if (skip) begin
               if (!last_entry) begin
                  idx_in   = idx_ff + 5'd1;
                  state_in = ST_LOAD;
               end else if (!pass2_ff) begin
                  // no multiplexor in use
                  pass2_in = 1'b1;
                  idx_in   = 5'd0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else begin
               pos_in     = {1'b0, desc_rd_ff.start_bit};
               len_in     = (desc_rd_ff.length > 7'd64) ? 7'd64 : desc_rd_ff.length;
               iss_cnt_in = 7'd0;
               rcv_cnt_in = 7'd0;
               acc_in     = '0;
               state_in   = ST_EXTRACT;
            end
         end

         // one payload read issued and one bit taken in per cycle
         ST_EXTRACT: begin
            if (iss_cnt_ff != len_ff) begin
               rd_go_in   = 1'b1;
               rd_off_in  = pos_ff[2:0];
               rd_ok_in   = pos_ff[POS_W-1:3] < frame_eff;
               iss_cnt_in = iss_cnt_ff + 7'd1;
               if (!desc_rd_ff.motorola) begin
                  pos_in = pos_ff + 10'd1;
               end else if (pos_ff[2:0] == 3'd0) begin
                  // motorola leaves bit 0 for bit 7 of the next byte
                  pos_in = pos_ff + 10'(MOTOROLA_JUMP);
               end else begin
                  pos_in = pos_ff - 10'd1;
               end
            end
            if (rd_go_ff) begin
               rcv_cnt_in = rcv_cnt_ff + 7'd1;
               if (desc_rd_ff.motorola) begin
                  acc_in = {acc_ff[VALUE_W-2:0], bit_val};
               end else begin
                  acc_in[rcv_cnt_ff[5:0]] = bit_val;
               end
            end
            if (rcv_cnt_in == len_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!pass2_ff) begin
               sel_in      = value_final;
               have_sel_in = 1'b1;
               pass2_in    = 1'b1;
               idx_in      = 5'd0;
               state_in    = ST_LOAD;
            end else begin
               acc_in   = value_final;
               state_in = ST_EMIT;
            end
         end

         // previous result goes out as not last, this one is held back
         ST_EMIT: begin
            if (!hold_vld_ff || out_free) begin
               if (hold_vld_ff) begin
                  rsp_vld_in   = 1'b1;
                  rsp_index_in = hold_index_ff;
                  rsp_value_in = hold_value_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_vld_in   = 1'b1;
               hold_index_in = idx_ff[3:0];
               hold_value_in = acc_ff;
               if (last_entry) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + 5'd1;
                  state_in = ST_LOAD;
               end
            end
         end

         ST_FLUSH: begin
            if (!hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_index_in = hold_index_ff;
               rsp_value_in = hold_value_ff;
               rsp_last_in  = 1'b1;
               hold_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
      end else begin
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_sel_ff <= 1'b0;
         rd_go_ff    <= 1'b0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         have_sel_ff <= have_sel_in;
         rd_go_ff    <= rd_go_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pass2_ff      <= pass2_in;
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      sel_ff        <= sel_in;
      pos_ff        <= pos_in;
      len_ff        <= len_in;
      iss_cnt_ff    <= iss_cnt_in;
      rcv_cnt_ff    <= rcv_cnt_in;
      acc_ff        <= acc_in;
      rd_off_ff     <= rd_off_in;
      rd_ok_ff      <= rd_ok_in;
      hold_index_ff <= hold_index_in;
      hold_value_ff <= hold_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.signal_index = rsp_index_ff;
   assign rsp_ch.value_bits   = rsp_value_ff;
   assign rsp_ch.last         = rsp_last_ff;

`ifndef SYNTHESIS
   // bits never come back faster than they were asked for
   a_rcv_le_iss: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXTRACT |-> rcv_cnt_ff <= iss_cnt_ff && iss_cnt_ff <= len_ff)
      else $error("payload bit pipeline out of step");

   // every decode hands out its held result before going idle
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_vld_ff)
      else $error("held result left behind at end of decode");

   // a multiplexed signal is only emitted under a matching selector
   a_muxed_sel: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && desc_rd_ff.role == ROLE_MUXED
      |-> have_sel_ff && sel_ff == {48'd0, desc_rd_ff.mux_value})
      else $error("multiplexed signal emitted without matching selector");

   // the table walk stays inside the entries in use
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> idx_ff < count_ff)
      else $error("descriptor index beyond signal count");
`endif

endmodule
